>>> src/piecewise_linear_calibration_eval_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the calibration evaluator
// Immediate-consequence and next-cycle implications, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_CALIBRATION_EVAL_CORE_MACROS_SVH
`define PIECEWISE_LINEAR_CALIBRATION_EVAL_CORE_MACROS_SVH

// same-cycle implication
`define PLCE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PLCE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/plce_pkg.sv
// ----------------------------------------------------------------------------
// plce_pkg
// Shared constants, types and helpers of the calibration evaluator.
// ----------------------------------------------------------------------------
package plce_pkg;

	localparam int MAX_CURVES  = 8;
	localparam int MAX_POINTS  = 16;
	localparam int TABLE_DEPTH = MAX_CURVES * MAX_POINTS;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CURVE_W     = (MAX_CURVES > 1) ? $clog2(MAX_CURVES) : 1;
	localparam int POINT_W     = $clog2(MAX_POINTS);
	localparam int PCNT_W      = $clog2(MAX_POINTS + 1);
	localparam int CNT_W       = $clog2(MAX_CURVES + 2);

	localparam int X_W    = 32;
	localparam int PROB_W = 15;
	localparam int SPAN_W = X_W + 1;
	localparam int DY_W   = PROB_W + 1;
	localparam int PROD_W = SPAN_W + DY_W;
	localparam int MAG_W  = PROD_W - 1;
	localparam int QBITS  = 17;
	localparam int QUO_W  = QBITS + 1;
	localparam int VAL_W  = QUO_W + 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	typedef logic [PROB_W-1:0] prob_t;

	localparam prob_t FULL_SCALE = 15'd25600;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CURVES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FILLS  = 2'd3;

	localparam logic [3:0] CURVES_RST = 4'd2;
	localparam logic [4:0] POINTS_RST = 5'd11;
	localparam logic [3:0] FILLS_RST  = 4'd0;

	function automatic logic [ADDR_W-1:0] tab_addr(
		input logic [CURVE_W-1:0] c,
		input logic [POINT_W-1:0] p
	);
		return ADDR_W'(int'(c) * MAX_POINTS + int'(p));
	endfunction

endpackage

>>> src/plce_div.sv
// ----------------------------------------------------------------------------
// plce_div
// Signed restoring divider, one quotient bit per cycle. The quotient
// truncates toward zero; a magnitude of 2^QBITS or more clamps to all ones.
// ----------------------------------------------------------------------------
module plce_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [plce_pkg::PROD_W-1:0]   num,
	input  logic signed [plce_pkg::SPAN_W-1:0]   den,
	output logic signed [plce_pkg::QUO_W-1:0]    quo,
	output logic                                 done
);
	import plce_pkg::*;

	localparam int DEN_W = SPAN_W;
	localparam int STEP_W = $clog2(QBITS + 1);

	logic [MAG_W-1:0]  num_mag;
	logic [DEN_W-1:0]  den_mag;
	logic              ovf;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    trial_sub;
	logic              take;

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [DEN_W-1:0]    rem_q;
	logic [QBITS-1:0]    low_q;
	logic [QBITS-1:0]    q_q;
	logic [DEN_W-1:0]    den_q;
	logic                neg_q;

	always_comb begin
		num_mag = num[PROD_W-1] ? MAG_W'(-num) : MAG_W'(num);
		den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
		ovf = DEN_W'(num_mag[MAG_W-1:QBITS]) >= den_mag;
		trial = {rem_q, low_q[QBITS-1]};
		take = trial >= {1'b0, den_q};
		trial_sub = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !ovf;
			done_q <= ovf;
			cnt_q  <= STEP_W'(QBITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			if (cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[PROD_W-1] ^ den[DEN_W-1];
			den_q <= den_mag;
			rem_q <= DEN_W'(num_mag[MAG_W-1:QBITS]);
			low_q <= num_mag[QBITS-1:0];
			q_q   <= ovf ? '1 : '0;
		end else if (busy_q) begin
			rem_q <= take ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
			low_q <= {low_q[QBITS-2:0], 1'b0};
			q_q   <= {q_q[QBITS-2:0], take};
		end
	end

	assign quo  = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
	assign done = done_q;

endmodule

>>> src/piecewise_linear_calibration_eval_core.sv
// ----------------------------------------------------------------------------
// piecewise_linear_calibration_eval_core
// Piecewise-linear evaluation of a set of calibration curves held in a
// breakpoint table.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): op selects a breakpoint load (curve_index,
// point_index, point_x, point_y) or the evaluation of datum. Results leave on
// out_valid/out_ready: one per curve in continuous mode, one per fill band in
// categorical mode, last marking the final one of a datum.
// Configuration is to be written on cfg_we/cfg_index/cfg_data only while the
// block idles; the user must keep to this, as the block does not enforce it.
// A load gives no result. Per result of an evaluation that uses a curve, the
// segment search reads one breakpoint x a cycle from the table memory, the
// segment ends are then fetched, and each interpolation over a segment of
// nonzero width runs through the bit-serial divider (one quotient bit per
// cycle). Items are taken one at a time; the next item is accepted while the
// final result still waits in the output register.
// A stalled receiver holds the output register and the sequencer waits.
// Reset clears the sequencer, the output valid flag and the configuration to
// its defaults; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module piecewise_linear_calibration_eval_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [plce_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [plce_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   op,
	input  logic [2:0]                             curve_index,
	input  logic [3:0]                             point_index,
	input  logic signed [31:0]                     point_x,
	input  logic [14:0]                            point_y,
	input  logic signed [31:0]                     datum,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [3:0]                             band_index,
	output logic [14:0]                            probability,
	output logic                                   degenerate,
	output logic                                   last
);
	import plce_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SETUP  = 4'd1;
	localparam logic [3:0] S_SEARCH = 4'd2;
	localparam logic [3:0] S_FETCH  = 4'd3;
	localparam logic [3:0] S_PREP   = 4'd4;
	localparam logic [3:0] S_MUL    = 4'd5;
	localparam logic [3:0] S_DIVGO  = 4'd6;
	localparam logic [3:0] S_DIV    = 4'd7;
	localparam logic [3:0] S_FIN    = 4'd8;
	localparam logic [3:0] S_OUT    = 4'd9;

	localparam logic [2:0] FETCH_LAST = 3'd4;

	logic [3:0] state_q;

	logic       mode_q;
	logic [3:0] curves_q;
	logic [4:0] points_q;
	logic [3:0] fills_q;

	logic [CNT_W-1:0]  nc;
	logic [CNT_W-1:0]  nf;
	logic [CNT_W-1:0]  n_res;
	logic [PCNT_W-1:0] p_eff;

	logic signed [X_W-1:0] break_x [TABLE_DEPTH];
	prob_t                 break_y [TABLE_DEPTH];
	logic signed [X_W-1:0] x_rd_q;
	prob_t                 y_rd_q;
	logic [ADDR_W-1:0]     x_raddr;
	logic [ADDR_W-1:0]     y_raddr;
	logic [ADDR_W-1:0]     waddr;
	logic                  mem_we;

	logic acc_in;
	logic out_free;
	logic last_res;

	logic signed [X_W-1:0] d_q;
	logic [CNT_W-1:0]      k_q;
	logic                  has_top_q;
	logic                  has_low_q;
	logic [CURVE_W-1:0]    g_q;
	logic [CURVE_W-1:0]    top_cv_q;
	logic [CURVE_W-1:0]    low_cv_q;
	logic [POINT_W-1:0]    i_q;
	logic [POINT_W-1:0]    cmp_i_q;
	logic                  cmp_vld_q;
	logic [POINT_W-1:0]    left_q;
	logic [2:0]            fc_q;
	logic signed [X_W-1:0] x0_q;
	logic signed [X_W-1:0] x1_q;
	prob_t                 yt0_q;
	prob_t                 yt1_q;
	prob_t                 yl0_q;
	prob_t                 yl1_q;
	logic signed [SPAN_W-1:0] dx_q;
	logic signed [SPAN_W-1:0] span_q;
	logic                  deg_q;
	logic                  side_q;
	logic signed [PROD_W-1:0] prod_q;
	prob_t                 upper_q;
	prob_t                 lower_q;

	logic                  out_valid_q;
	logic [3:0]            band_q;
	prob_t                 prob_q;
	logic                  deg_out_q;
	logic                  last_q;

	logic                  ht;
	logic                  hl;
	logic [CURVE_W-1:0]    g_nx;
	prob_t                 lo_def;
	logic                  hit;
	logic                  srch_done;
	logic [POINT_W-1:0]    left_nx;
	logic [POINT_W-1:0]    left_p1;
	logic signed [PROD_W-1:0] dx_ext;
	logic signed [PROD_W-1:0] dy_ext;
	prob_t                 y0_sel;
	logic signed [VAL_W-1:0] v;
	prob_t                 v_sat;
	logic [PROB_W:0]       diff;
	prob_t                 diff_sat;

	logic                  div_start;
	logic                  div_done;
	logic signed [QUO_W-1:0] quo;

	// effective register values
	always_comb begin
		if (int'(curves_q) > MAX_CURVES) nc = CNT_W'(MAX_CURVES);
		else nc = CNT_W'(curves_q);
		if (int'(fills_q) > MAX_CURVES + 1) nf = CNT_W'(MAX_CURVES + 1);
		else nf = CNT_W'(fills_q);
		if (points_q < 5'd2) p_eff = PCNT_W'(2);
		else if (int'(points_q) > MAX_POINTS) p_eff = PCNT_W'(MAX_POINTS);
		else p_eff = PCNT_W'(points_q);
		n_res = mode_q ? nf : nc;
	end

	assign acc_in   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign last_res = (k_q == n_res - CNT_W'(1));
	assign mem_we   = acc_in && (op == OP_LOAD) && (int'(curve_index) < MAX_CURVES)
		&& (int'(point_index) < MAX_POINTS);
	assign waddr    = tab_addr(CURVE_W'(curve_index), POINT_W'(point_index));

	// band bounds for the current result
	always_comb begin
		if (mode_q) begin
			ht = k_q < nc;
			hl = (k_q != '0) && (k_q <= nc);
		end else begin
			ht = 1'b1;
			hl = 1'b0;
		end
		g_nx = ht ? CURVE_W'(k_q) : CURVE_W'(k_q - CNT_W'(1));
		lo_def = (mode_q && k_q != '0) ? FULL_SCALE : '0;
	end

	// segment search
	always_comb begin
		hit = cmp_vld_q && (d_q <= x_rd_q);
		srch_done = hit || (cmp_vld_q && (PCNT_W'(cmp_i_q) == p_eff - PCNT_W'(1)));
		if (hit) left_nx = (cmp_i_q == '0) ? '0 : cmp_i_q - POINT_W'(1);
		else left_nx = POINT_W'(p_eff - PCNT_W'(2));
		left_p1 = left_q + POINT_W'(1);
	end

	// table read addresses
	always_comb begin
		if (state_q == S_SEARCH) x_raddr = tab_addr(g_q, i_q);
		else if (fc_q == 3'd0) x_raddr = tab_addr(g_q, left_q);
		else x_raddr = tab_addr(g_q, left_p1);
		case (fc_q)
			3'd0:    y_raddr = tab_addr(top_cv_q, left_q);
			3'd1:    y_raddr = tab_addr(top_cv_q, left_p1);
			3'd2:    y_raddr = tab_addr(low_cv_q, left_q);
			default: y_raddr = tab_addr(low_cv_q, left_p1);
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			break_x[waddr] <= point_x;
			break_y[waddr] <= point_y;
		end
		x_rd_q <= break_x[x_raddr];
		y_rd_q <= break_y[y_raddr];
	end

	// interpolation arithmetic
	always_comb begin
		dx_ext = PROD_W'(dx_q);
		if (side_q) dy_ext = PROD_W'($signed({1'b0, yl1_q}) - $signed({1'b0, yl0_q}));
		else dy_ext = PROD_W'($signed({1'b0, yt1_q}) - $signed({1'b0, yt0_q}));
		y0_sel = side_q ? yl0_q : yt0_q;
		if (deg_q) v = $signed(VAL_W'(y0_sel));
		else v = $signed(VAL_W'(y0_sel)) + VAL_W'(quo);
		if (v < 0) v_sat = '0;
		else if (v > $signed(VAL_W'(FULL_SCALE))) v_sat = FULL_SCALE;
		else v_sat = v[PROB_W-1:0];
		diff = {1'b0, upper_q} - {1'b0, lower_q};
		diff_sat = diff[PROB_W] ? '0 : diff[PROB_W-1:0];
	end

	assign div_start = (state_q == S_DIVGO);

	plce_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod_q),
		.den    (span_q),
		.quo    (quo),
		.done   (div_done)
	);

	// sequencer and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= 1'b0;
			curves_q    <= CURVES_RST;
			points_q    <= POINTS_RST;
			fills_q     <= FILLS_RST;
			k_q         <= '0;
			i_q         <= '0;
			cmp_i_q     <= '0;
			cmp_vld_q   <= 1'b0;
			fc_q        <= '0;
			side_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MODE:   mode_q   <= cfg_data[0];
					CFG_CURVES: curves_q <= cfg_data[3:0];
					CFG_POINTS: points_q <= cfg_data[4:0];
					CFG_FILLS:  fills_q  <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc_in && op == OP_EVAL && n_res != '0) begin
						k_q     <= '0;
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					i_q       <= '0;
					cmp_vld_q <= 1'b0;
					state_q   <= (ht || hl) ? S_SEARCH : S_OUT;
				end
				S_SEARCH: begin
					i_q       <= i_q + POINT_W'(1);
					cmp_i_q   <= i_q;
					cmp_vld_q <= 1'b1;
					if (srch_done) begin
						fc_q    <= '0;
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					fc_q <= fc_q + 3'd1;
					if (fc_q == FETCH_LAST) state_q <= S_PREP;
				end
				S_PREP: begin
					side_q  <= !has_top_q;
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= deg_q ? S_FIN : S_DIVGO;
				end
				S_DIVGO: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) state_q <= S_FIN;
				end
				S_FIN: begin
					if (!side_q && has_low_q) begin
						side_q  <= 1'b1;
						state_q <= S_MUL;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						if (last_res) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + CNT_W'(1);
							state_q <= S_SETUP;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (acc_in && op == OP_EVAL) d_q <= datum;
		case (state_q)
			S_SETUP: begin
				has_top_q <= ht;
				has_low_q <= hl;
				g_q       <= g_nx;
				top_cv_q  <= CURVE_W'(k_q);
				low_cv_q  <= CURVE_W'(k_q - CNT_W'(1));
				upper_q   <= FULL_SCALE;
				lower_q   <= lo_def;
				deg_q     <= 1'b0;
			end
			S_SEARCH: begin
				if (srch_done) left_q <= left_nx;
			end
			S_FETCH: begin
				case (fc_q)
					3'd1: begin
						x0_q  <= x_rd_q;
						yt0_q <= y_rd_q;
					end
					3'd2: begin
						x1_q  <= x_rd_q;
						yt1_q <= y_rd_q;
					end
					3'd3:    yl0_q <= y_rd_q;
					3'd4:    yl1_q <= y_rd_q;
					default: ;
				endcase
			end
			S_PREP: begin
				dx_q   <= SPAN_W'(d_q) - SPAN_W'(x0_q);
				span_q <= SPAN_W'(x1_q) - SPAN_W'(x0_q);
				deg_q  <= (x1_q == x0_q);
			end
			S_MUL: begin
				prod_q <= dx_ext * dy_ext;
			end
			S_FIN: begin
				if (side_q) lower_q <= v_sat;
				else upper_q <= v_sat;
			end
			S_OUT: begin
				if (out_free) begin
					band_q    <= 4'(k_q);
					prob_q    <= diff_sat;
					deg_out_q <= deg_q;
					last_q    <= last_res;
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign band_index  = band_q;
	assign probability = prob_q;
	assign degenerate  = deg_out_q;
	assign last        = last_q;

endmodule

>>> src/plce_chk.sv
// ----------------------------------------------------------------------------
// plce_chk
// Port-level checks of the calibration evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "piecewise_linear_calibration_eval_core_macros.svh"

module plce_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        op,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  band_index,
	input logic [14:0] probability,
	input logic        last
);
	import plce_pkg::*;

	`PLCE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(probability) && $stable(band_index) && $stable(last), "stalled result changed")
	`PLCE_ASSERT_SAME(a_prob_range, out_valid, probability <= FULL_SCALE, "probability above full scale")
	`PLCE_ASSERT_SAME(a_band_range, out_valid, int'(band_index) <= MAX_CURVES, "band index out of range")
	`PLCE_ASSERT_SAME(a_busy_mid, out_valid && !last, !in_ready, "new transaction taken before last result")
	`PLCE_ASSERT_NEXT(a_load_quiet, in_valid && in_ready && op == OP_LOAD && !out_valid, !out_valid, "load produced a result")

endmodule

bind piecewise_linear_calibration_eval_core plce_chk u_plce_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.op          (op),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.band_index  (band_index),
	.probability (probability),
	.last        (last)
);

>>> dv/piecewise_linear_calibration_eval_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Calibration curve evaluator testbench
// Loads breakpoint tables, sweeps the configuration registers and feeds load
// and evaluate transactions with random bursts and output back-pressure. An
// in-bench curve predictor turns every accepted datum into the expected
// per-curve or per-band probabilities, and each result is checked in order.
// ----------------------------------------------------------------------------
module piecewise_linear_calibration_eval_core_tb;
	import plce_pkg::*;

	localparam logic   MODE_CONT     = 1'b0;
	localparam logic   MODE_CAT      = 1'b1;
	localparam longint FULL_PCT      = FULL_SCALE;
	localparam int     CYCLE_LIMIT   = 1_000_000;
	localparam int     SETTLE_CYCLES = 8;
	localparam int     DRAIN_CYCLES  = 200;
	localparam int     RANDOM_PHASES = 2;
	localparam int     PHASE_ITEMS   = 5;

	typedef struct packed {
		logic [3:0] band;
		prob_t      prob;
		logic       deg;
		logic       last;
	} band_result_t;

	logic                         clk;
	logic                         arst_n      = 1'b0;
	logic                         cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]         cfg_index   = '0;
	logic [CFG_DATA_W-1:0]        cfg_data    = '0;
	logic                         in_valid    = 1'b0;
	logic                         in_ready;
	logic                         op          = OP_LOAD;
	logic [2:0]                   curve_index = '0;
	logic [3:0]                   point_index = '0;
	logic signed [31:0]           point_x     = '0;
	logic [14:0]                  point_y     = '0;
	logic signed [31:0]           datum       = '0;
	logic                         out_valid;
	logic                         out_ready   = 1'b0;
	logic [3:0]                   band_index;
	logic [14:0]                  probability;
	logic                         degenerate;
	logic                         last;

	logic signed [31:0] model_x [TABLE_DEPTH];
	logic [14:0]        model_y [TABLE_DEPTH];
	logic               cur_mode   = MODE_CONT;
	logic [3:0]         cur_curves = CURVES_RST;
	logic [4:0]         cur_points = POINTS_RST;
	logic [3:0]         cur_fills  = FILLS_RST;

	band_result_t expected_probs [$];
	band_result_t want_result;

	int burst_left  = 0;
	int ready_hold  = 0;
	int ready_style = 0;
	int error_count = 0;
	int cycle_count = 0;
	int n_loads     = 0;
	int n_evals     = 0;
	int n_results   = 0;
	int n_reg_writes = 0;

	piecewise_linear_calibration_eval_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.curve_index (curve_index),
		.point_index (point_index),
		.point_x     (point_x),
		.point_y     (point_y),
		.datum       (datum),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.band_index  (band_index),
		.probability (probability),
		.degenerate  (degenerate),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycle_count, expected_probs.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver back-pressure: runs of always-ready, light and heavy stalling
	always @(negedge clk) begin
		if (ready_hold == 0) begin
			ready_hold  = $urandom_range(1, 40);
			ready_style = $urandom_range(0, 3);
		end
		ready_hold--;
		case (ready_style)
			0, 1: begin
				out_ready = 1'b1;
			end
			2: begin
				out_ready = 1'($urandom_range(0, 1));
			end
			default: begin
				out_ready = ($urandom_range(0, 3) == 0);
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (expected_probs.size() == 0) begin
				$error("unexpected result: band_index %0d probability %0d", band_index,
					probability);
				error_count++;
			end else begin
				want_result = expected_probs.pop_front();
				if (band_index !== want_result.band) begin
					$error("band_index mismatch: expected %0d, actual %0d",
						want_result.band, band_index);
					error_count++;
				end
				if (probability !== want_result.prob) begin
					$error("probability mismatch: expected %0d, actual %0d",
						want_result.prob, probability);
					error_count++;
				end
				if (degenerate !== want_result.deg) begin
					$error("degenerate mismatch: expected %0d, actual %0d",
						want_result.deg, degenerate);
					error_count++;
				end
				if (last !== want_result.last) begin
					$error("last mismatch: expected %0d, actual %0d",
						want_result.last, last);
					error_count++;
				end
			end
		end
	end

	function automatic int active_points();
		int p;
		p = cur_points;
		if (p < 2) p = 2;
		if (p > MAX_POINTS) p = MAX_POINTS;
		return p;
	endfunction

	function automatic int active_curves();
		return (cur_curves > MAX_CURVES) ? MAX_CURVES : int'(cur_curves);
	endfunction

	function automatic void find_segment(input int c, input longint d, output int left,
		output longint dx, output longint span);
		int  base;
		int  npts;
		int  i;
		bit  hit;
		base = c * MAX_POINTS;
		npts = active_points();
		left = npts - 2;
		hit  = 1'b0;
		for (i = 0; i < npts; i++) begin
			if (!hit && d <= longint'(model_x[base + i])) begin
				left = (i == 0) ? 0 : i - 1;
				hit  = 1'b1;
			end
		end
		dx   = d - longint'(model_x[base + left]);
		span = longint'(model_x[base + left + 1]) - longint'(model_x[base + left]);
	endfunction

	function automatic longint curve_value(input int c, input int left, input longint dx,
		input longint span);
		longint y0;
		longint y1;
		y0 = longint'(model_y[c * MAX_POINTS + left]);
		y1 = longint'(model_y[c * MAX_POINTS + left + 1]);
		if (span == 0) return y0;
		return y0 + (dx * (y1 - y0)) / span;
	endfunction

	function automatic longint clamp_pct(input longint v);
		if (v < 0) return 0;
		if (v > FULL_PCT) return FULL_PCT;
		return v;
	endfunction

	function automatic void push_expected(input int idx, input longint prob, input bit deg);
		band_result_t r;
		r.band = idx[3:0];
		r.prob = prob[14:0];
		r.deg  = deg;
		r.last = 1'b0;
		expected_probs.insert(expected_probs.size(), r);
	endfunction

	function automatic void predict_datum(input logic signed [31:0] datum_in);
		longint       d;
		longint       dx;
		longint       span;
		longint       upper;
		longint       lower;
		int           left;
		int           nc;
		int           nf;
		int           n;
		bit           has_top;
		bit           has_low;
		bit           deg;
		band_result_t tail;
		d  = datum_in;
		nc = active_curves();
		n  = 0;
		if (cur_mode == MODE_CONT) begin
			for (int c = 0; c < nc; c++) begin
				find_segment(c, d, left, dx, span);
				push_expected(c, clamp_pct(curve_value(c, left, dx, span)), span == 0);
				n++;
			end
		end else begin
			nf = (cur_fills > MAX_CURVES + 1) ? MAX_CURVES + 1 : int'(cur_fills);
			for (int b = 0; b < nf; b++) begin
				has_top = (b < nc);
				has_low = (b >= 1) && (b - 1 < nc);
				upper   = FULL_PCT;
				lower   = (b == 0) ? 0 : FULL_PCT;
				deg     = 1'b0;
				if (has_top || has_low) begin
					find_segment(has_top ? b : b - 1, d, left, dx, span);
					deg = (span == 0);
					if (has_top) upper = clamp_pct(curve_value(b, left, dx, span));
					if (has_low) lower = clamp_pct(curve_value(b - 1, left, dx, span));
				end
				push_expected(b, clamp_pct(upper - lower), deg);
				n++;
			end
		end
		if (n > 0) begin
			tail      = expected_probs[expected_probs.size() - 1];
			tail.last = 1'b1;
			expected_probs[expected_probs.size() - 1] = tail;
		end
	endfunction

	task automatic send_item(input logic opc, input logic [2:0] ci, input logic [3:0] pi,
		input logic signed [31:0] px, input logic [14:0] py, input logic signed [31:0] dv);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid    = 1'b1;
		op          = opc;
		curve_index = ci;
		point_index = pi;
		point_x     = px;
		point_y     = py;
		datum       = dv;
		do @(posedge clk); while (!in_ready);
		if (opc == OP_LOAD) begin
			model_x[int'(ci) * MAX_POINTS + int'(pi)] = px;
			model_y[int'(ci) * MAX_POINTS + int'(pi)] = py;
			n_loads++;
		end else begin
			predict_datum(dv);
			n_evals++;
		end
	endtask

	task automatic load_point(input int c, input int p, input logic signed [31:0] x,
		input logic [14:0] y);
		send_item(OP_LOAD, c[2:0], p[3:0], x, y, $urandom);
	endtask

	task automatic eval_datum(input logic signed [31:0] d);
		send_item(OP_EVAL, 3'($urandom), 4'($urandom), 32'($urandom), 15'($urandom), d);
	endtask

	// drop valid, wait for every result, then let the pipeline settle
	task automatic wait_quiet();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_probs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_MODE:   cur_mode   = val[0];
			CFG_CURVES: cur_curves = val[3:0];
			CFG_POINTS: cur_points = val[4:0];
			CFG_FILLS:  cur_fills  = val[3:0];
			default: ;
		endcase
		n_reg_writes++;
	endtask

	task automatic set_config(input logic m, input logic [3:0] nc, input logic [4:0] np,
		input logic [3:0] nf);
		wait_quiet();
		write_reg(CFG_MODE, {4'd0, m});
		write_reg(CFG_CURVES, {1'b0, nc});
		write_reg(CFG_POINTS, np);
		write_reg(CFG_FILLS, {1'b0, nf});
	endtask

	function automatic logic signed [31:0] pick_datum();
		int     sel;
		int     c;
		int     p;
		longint v;
		sel = $urandom_range(0, 99);
		c   = $urandom_range(0, active_curves() - 1);
		p   = $urandom_range(0, active_points() - 1);
		v   = model_x[c * MAX_POINTS + p];
		if (sel < 15) begin
		end else if (sel < 65) begin
			v = v + longint'($urandom_range(0, 1 << 18)) - (1 << 17);
		end else if (sel < 88) begin
			v = longint'($signed($urandom));
		end else begin
			v = sel[0] ? 64'sh7FFF_FFFF : -64'sh8000_0000;
		end
		return 32'(v);
	endfunction

	// every table entry gets a value first; curves ascend with random, sometimes zero, steps
	task automatic test_table_load();
		longint x;
		int     step;
		for (int c = 0; c < MAX_CURVES; c++) begin
			x = -longint'($urandom_range(0, 1 << 28));
			for (int p = 0; p < MAX_POINTS; p++) begin
				load_point(c, p, 32'(x), 15'($urandom_range(0, FULL_PCT)));
				step = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1 << 24);
				x    = x + step;
			end
		end
	endtask

	// segment below, between, exactly on and above the breakpoints,
	// zero-width segments at both ends, saturation and truncation
	task automatic test_segment_edges();
		set_config(MODE_CONT, 4'd3, 5'd4, 4'd0);
		load_point(0, 0, 32'sh8000_0000, 15'd0);
		load_point(0, 1, 32'sh8000_0000, 15'd25600);
		load_point(0, 2, 32'sd0, 15'd12800);
		load_point(0, 3, 32'sh7FFF_FFFF, 15'd25600);
		load_point(1, 0, -32'sd1000, 15'd25600);
		load_point(1, 1, -32'sd500, 15'd0);
		load_point(1, 2, 32'sd500, 15'd25600);
		load_point(1, 3, 32'sd600, 15'd1);
		load_point(2, 0, 32'sd0, 15'd100);
		load_point(2, 1, 32'sd10, 15'd200);
		load_point(2, 2, 32'sd20, 15'd300);
		load_point(2, 3, 32'sd20, 15'd400);
		eval_datum(32'sh8000_0000);
		eval_datum(32'sd0);
		eval_datum(32'sd510);
		eval_datum(32'sd1600);
		eval_datum(32'sd30);
		eval_datum(32'sh7FFF_FFFF);
	endtask

	// bands at the low edge, between curves, above the last curve and beyond
	task automatic test_band_edges();
		set_config(MODE_CAT, 4'd3, 5'd4, 4'd9);
		eval_datum(32'sd510);
		eval_datum(32'sd30);
		set_config(MODE_CAT, 4'd3, 5'd4, 4'd0);
		eval_datum(32'sd0);
	endtask

	task automatic test_register_extremes();
		set_config(MODE_CONT, 4'd8, 5'd16, 4'd0);
		eval_datum(pick_datum());
		set_config(MODE_CONT, 4'd1, 5'd2, 4'd0);
		eval_datum(pick_datum());
		set_config(MODE_CAT, 4'd8, 5'd16, 4'd9);
		eval_datum(pick_datum());
	endtask

	task automatic test_random_traffic();
		int               c;
		int               p;
		logic signed [31:0] x;
		logic [14:0]      y;
		int               sel;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_config(1'($urandom_range(0, 1)), 4'($urandom_range(1, MAX_CURVES)),
				5'($urandom_range(2, MAX_POINTS)), 4'($urandom_range(0, MAX_CURVES + 1)));
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 3) == 0) begin
					c   = $urandom_range(0, MAX_CURVES - 1);
					p   = $urandom_range(0, MAX_POINTS - 1);
					sel = $urandom_range(0, 9);
					if (sel < 7)
						x = model_x[c * MAX_POINTS + p] + $signed($urandom_range(0, 8192)) - 4096;
					else
						x = $urandom;
					if (sel == 0)
						y = 15'd0;
					else if (sel == 1)
						y = FULL_SCALE;
					else
						y = 15'($urandom_range(0, FULL_PCT));
					load_point(c, p, x, y);
				end else begin
					eval_datum(pick_datum());
				end
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_table_load();
		test_segment_edges();
		test_band_edges();
		test_register_extremes();
		test_random_traffic();
		wait_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d breakpoint loads and %0d datum evaluations over %0d register writes",
			n_loads, n_evals, n_reg_writes);
		$display("Checked %0d results in %0d cycles, %0d mismatches", n_results, cycle_count,
			error_count);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> piecewise_linear_calibration_eval_core.f
+incdir+src
src/plce_pkg.sv
src/plce_div.sv
src/piecewise_linear_calibration_eval_core.sv
src/plce_chk.sv
dv/piecewise_linear_calibration_eval_core_tb.sv
